/* sv/lpr_pkg.sv */
// Shared types and field widths for the LRU page replacer.
package lpr_pkg;

	localparam int PROC_IDX_W = 4;
	localparam int PC_W       = 11;
	localparam int MAP_W      = 16;
	localparam int ACT_W      = 2;
	localparam int PAGE_IDX_W = 4;
	localparam int STAMP_W    = 32;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE    = 2'd0,
		ACT_PAGEIN  = 2'd1,
		ACT_PAGEOUT = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_DONE
	} lpr_state_t;

endpackage

/* sv/lpr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/lru_page_replacer.sv */
// LRU page replacer top level: stamp table in RAM, sequencer and victim scan.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  in      | input     | in_valid / in_stall  | process_index, process_active, pc_value,
//          |           |                     | resident_map, pagein_ok, end_of_sweep
//  out     | output    | out_valid / out_stall| action, target_page, target_process, no_victim
//
// One item in flight. After the transfer, an evaluate state writes the stamp; items that
// need no victim then go through the done state to the output register. A refused page-in
// scans all NUM_PAGES stamps of the process through the single RAM read port.
// After reset the stamp RAM, NUM_PROCS times NUM_PAGES entries with each rounded up to a
// power of two, is zeroed one entry per cycle; in_stall is high meanwhile.
// The output register holds a finished result under out_stall; the next item is taken while
// it waits and parks in the done state until the register frees.
module lru_page_replacer
	import lpr_pkg::*;
#(
	parameter int NUM_PROCS  = 16,
	parameter int NUM_PAGES  = 16,
	parameter int PAGE_BYTES = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PROC_IDX_W-1:0] process_index,
	input  logic                  process_active,
	input  logic [PC_W-1:0]       pc_value,
	input  logic [MAP_W-1:0]      resident_map,
	input  logic                  pagein_ok,
	input  logic                  end_of_sweep,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ACT_W-1:0]      action,
	output logic [PAGE_IDX_W-1:0] target_page,
	output logic [PROC_IDX_W-1:0] target_process,
	output logic                  no_victim
);

	// Table geometry: {process, page} address, each part rounded up to a power of two.
	localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int PG_W   = $clog2(NUM_PAGES);
	localparam int ADDR_W = PROC_W + PG_W;
	localparam int DEPTH  = 2 ** ADDR_W;
	localparam int CNT_W  = PG_W + 1;

	// pc / PAGE_BYTES by reciprocal multiply, exact for every 11-bit pc.
	localparam int DIV_LOG = $clog2(PAGE_BYTES);
	localparam int DIV_SH  = PC_W + 1 + DIV_LOG;
	localparam int RECIP   = (2 ** DIV_SH + PAGE_BYTES - 1) / PAGE_BYTES;
	localparam int RECIP_W = PC_W + 3;
	localparam int PROD_W  = PC_W + RECIP_W;

	lpr_state_t state_q, state_d;

	// tick and clear sweep
	logic [STAMP_W-1:0] tick_q;
	logic [ADDR_W-1:0]  clr_q;

	// accepted item, stage 1
	logic                  work_s1;
	logic                  need_res_s1;
	logic                  ok_s1;
	logic [PROC_IDX_W-1:0] proc_s1;
	logic [PROC_W-1:0]     proc_addr_s1;
	logic [PG_W-1:0]       page_s1;
	logic [MAP_W-1:0]      map_s1;
	logic [STAMP_W-1:0]    stamp_s1;

	// victim scan
	logic [CNT_W-1:0]   scan_q;
	logic               cmp_vld_q;
	logic [PG_W-1:0]    cmp_pg_q;
	logic               found_q;
	logic [PG_W-1:0]    best_q;
	logic [STAMP_W-1:0] best_stamp_q;

	// pending result and output register
	action_t               res_action_q;
	logic [PG_W-1:0]       res_page_q;
	logic                  res_novict_q;
	logic                  out_valid_q;
	action_t               out_action_q;
	logic [PAGE_IDX_W-1:0] out_page_q;
	logic [PROC_IDX_W-1:0] out_proc_q;
	logic                  out_novict_q;

	// RAM port
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [STAMP_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [STAMP_W-1:0] ram_rdata;

	// control
	logic in_xfer;
	logic need_scan;
	logic scan_issue;
	logic scan_end;
	logic load_out;

	// input decode
	logic [PROD_W-1:0] pc_prod;
	logic [PC_W-1:0]   page_full;
	logic [7:0]        proc_ext;
	logic              proc_in_range;
	logic              page_in_range;
	logic              page_res_in;

	// scan compare
	logic [PAGE_IDX_W-1:0] cmp_map_idx;
	logic                  cmp_resident;
	logic                  cmp_better;

	assign pc_prod       = PROD_W'(pc_value) * PROD_W'(RECIP);
	assign page_full     = PC_W'(pc_prod >> DIV_SH);
	assign proc_ext      = 8'(process_index);
	assign proc_in_range = 32'(process_index) < 32'(NUM_PROCS);
	assign page_in_range = 32'(page_full) < 32'(NUM_PAGES);
	// pages past the map width are never resident
	assign page_res_in   = (32'(page_full) < 32'(MAP_W)) &&
		resident_map[page_full[PAGE_IDX_W-1:0]];

	assign in_xfer   = in_valid && !in_stall;
	assign need_scan = work_s1 && !need_res_s1 && !ok_s1;
	assign scan_end  = (scan_q == CNT_W'(NUM_PAGES)) && !cmp_vld_q;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign cmp_map_idx  = PAGE_IDX_W'(cmp_pg_q);
	assign cmp_resident = (32'(cmp_pg_q) < 32'(MAP_W)) && map_s1[cmp_map_idx];
	// strict less-than keeps the lowest page on equal stamps
	assign cmp_better   = cmp_vld_q && cmp_resident &&
		(!found_q || (ram_rdata < best_stamp_q));

	lpr_ram #(
		.WIDTH(STAMP_W),
		.DEPTH(DEPTH)
	) u_stamp_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		ram_we     = 1'b0;
		ram_waddr  = clr_q;
		ram_wdata  = '0;
		ram_raddr  = {proc_addr_s1, scan_q[PG_W-1:0]};
		scan_issue = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				ram_we    = work_s1;
				ram_waddr = {proc_addr_s1, page_s1};
				ram_wdata = stamp_s1;
				state_d   = need_scan ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				scan_issue = (scan_q != CNT_W'(NUM_PAGES));
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= STAMP_W'(1);
			clr_q       <= '0;
			scan_q      <= '0;
			cmp_vld_q   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			// the stamp of this item is captured before the tick moves
			if (in_xfer && end_of_sweep) begin
				tick_q <= tick_q + STAMP_W'(1);
			end
			if (state_q == ST_EVAL) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (scan_issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			cmp_vld_q <= scan_issue;
			if (cmp_better) begin
				found_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			work_s1      <= process_active && proc_in_range && page_in_range;
			need_res_s1  <= page_res_in;
			ok_s1        <= pagein_ok;
			proc_s1      <= process_index;
			proc_addr_s1 <= proc_ext[PROC_W-1:0];
			page_s1      <= page_full[PG_W-1:0];
			map_s1       <= resident_map;
			stamp_s1     <= tick_q;
		end
		cmp_pg_q <= scan_q[PG_W-1:0];
		if (cmp_better) begin
			best_q       <= cmp_pg_q;
			best_stamp_q <= ram_rdata;
		end
		if (state_q == ST_EVAL) begin
			res_novict_q <= 1'b0;
			res_page_q   <= page_s1;
			if (work_s1 && !need_res_s1 && ok_s1) begin
				res_action_q <= ACT_PAGEIN;
			end else begin
				res_action_q <= ACT_NONE;
			end
		end else if ((state_q == ST_SCAN) && scan_end) begin
			res_page_q   <= best_q;
			res_action_q <= found_q ? ACT_PAGEOUT : ACT_NONE;
			res_novict_q <= !found_q;
		end
		if (load_out) begin
			out_action_q <= res_action_q;
			out_novict_q <= res_novict_q;
			if (res_action_q == ACT_NONE) begin
				out_page_q <= '0;
				out_proc_q <= '0;
			end else begin
				out_page_q <= PAGE_IDX_W'(res_page_q);
				out_proc_q <= proc_s1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign action         = out_action_q;
	assign target_page    = out_page_q;
	assign target_process = out_proc_q;
	assign no_victim      = out_novict_q;

	// Assertions

	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && end_of_sweep) |=> (tick_q == $past(tick_q) + STAMP_W'(1)))
		else $error("tick did not advance after end of sweep");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !ram_we)
		else $error("stamp write during victim scan");

	a_none_zero_targets: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_action_q == ACT_NONE)) |->
		((out_page_q == '0) && (out_proc_q == '0)))
		else $error("targets not zero on no action");

	a_novict_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_novict_q) |-> (out_action_q == ACT_NONE))
		else $error("no_victim with an action");

	a_xfer_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_EVAL))
		else $error("accepted item not evaluated");

endmodule

/* test/lru_page_replacer_test.sv */
`timescale 1ns / 1ps
// Testbench for lru_page_replacer: directed LRU cases, then random sweeps against a predictor.
module lru_page_replacer_test
	import lpr_pkg::*;
();

	// Block configuration as instantiated; page of an entry is pc / PAGE_SZ
	localparam int NPROC   = 16;
	localparam int NPAGE   = 16;
	localparam int PAGE_SZ = 128;

	// Stimulus size and run limits
	localparam int NUM_ENTRIES     = 1550; // entries offered over the whole run
	localparam int HOLD_OFF_START  = 300;  // results seen before the long receiver hold-off
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int IDLE_LIMIT      = 4000; // cycles without any transfer before giving up
	localparam int DRAIN_CYCLES    = 60;

	typedef struct packed {
		logic [PROC_IDX_W-1:0] idx;
		logic                  active;
		logic [PC_W-1:0]       pc;
		logic [MAP_W-1:0]      map;
		logic                  ok;
		logic                  eos;
	} proc_entry_t;

	typedef struct packed {
		action_t               act;
		logic [PAGE_IDX_W-1:0] page;
		logic [PROC_IDX_W-1:0] proc_id;
		logic                  nv;
	} replace_t;

	// Receiver stall styles, each held for a random stretch before the next is drawn
	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} rx_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PROC_IDX_W-1:0] process_index = '0;
	logic                  process_active = 1'b0;
	logic [PC_W-1:0]       pc_value = '0;
	logic [MAP_W-1:0]      resident_map = '0;
	logic                  pagein_ok = 1'b0;
	logic                  end_of_sweep = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ACT_W-1:0]      action;
	logic [PAGE_IDX_W-1:0] target_page;
	logic [PROC_IDX_W-1:0] target_process;
	logic                  no_victim;

	lru_page_replacer #(
		.NUM_PROCS  (NPROC),
		.NUM_PAGES  (NPAGE),
		.PAGE_BYTES (PAGE_SZ)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.process_index  (process_index),
		.process_active (process_active),
		.pc_value       (pc_value),
		.resident_map   (resident_map),
		.pagein_ok      (pagein_ok),
		.end_of_sweep   (end_of_sweep),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.action         (action),
		.target_page    (target_page),
		.target_process (target_process),
		.no_victim      (no_victim)
	);

	always #4 clk = ~clk;

	// Predictor state: per-process, per-page last-use stamps and the sweep tick
	logic [STAMP_W-1:0] use_stamp [NPROC][NPAGE];
	logic [STAMP_W-1:0] sweep_tick;

	proc_entry_t pending_entries[$];   // entries not yet offered
	replace_t    expected_actions[$];  // predicted results, oldest first

	int errors = 0;
	int entries_sent = 0;
	int results_seen = 0;
	int n_pagein = 0;
	int n_pageout = 0;
	int n_novictim = 0;
	int n_none = 0;

	// Stamp the needed page and pick page-in, LRU victim or nothing.
	// Victim search keeps the first minimum, so ties go to the lowest page.
	function automatic replace_t predict_replacement(input proc_entry_t e);
		replace_t r;
		int unsigned pg;
		bit found;
		int unsigned best;
		logic [STAMP_W-1:0] best_stamp;
		r.act = ACT_NONE;
		r.page = '0;
		r.proc_id = '0;
		r.nv = 1'b0;
		found = 1'b0;
		best = 0;
		best_stamp = '0;
		if (e.active && e.idx < NPROC) begin
			pg = e.pc / PAGE_SZ;
			if (pg < NPAGE) begin
				use_stamp[e.idx][pg] = sweep_tick;
				// pages beyond the resident map never count as resident
				if (!(pg < MAP_W && e.map[pg])) begin
					if (e.ok) begin
						r.act = ACT_PAGEIN;
						r.page = PAGE_IDX_W'(pg);
						r.proc_id = e.idx;
					end else begin
						for (int p = 0; p < NPAGE && p < MAP_W; p++) begin
							if (e.map[p] && (!found || use_stamp[e.idx][p] < best_stamp)) begin
								found = 1'b1;
								best = p;
								best_stamp = use_stamp[e.idx][p];
							end
						end
						if (found) begin
							r.act = ACT_PAGEOUT;
							r.page = PAGE_IDX_W'(best);
							r.proc_id = e.idx;
						end else begin
							r.nv = 1'b1;
						end
					end
				end
			end
		end
		if (e.eos)
			sweep_tick = sweep_tick + STAMP_W'(1);
		case (r.act)
		ACT_PAGEIN:  n_pagein++;
		ACT_PAGEOUT: n_pageout++;
		default:     if (r.nv) n_novictim++; else n_none++;
		endcase
		return r;
	endfunction

	task automatic push_entry(input int idx, input int act, input int pc, input int map,
	                          input int ok, input int eos);
		proc_entry_t e;
		e.idx = PROC_IDX_W'(idx);
		e.active = act[0];
		e.pc = PC_W'(pc);
		e.map = MAP_W'(map);
		e.ok = ok[0];
		e.eos = eos[0];
		pending_entries.push_back(e);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] want,
	                               input logic [31:0] got);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		errors++;
	endtask

	// ---------------------------------------------------------------------
	// Sender: offers queued entries in bursts with random gaps in between.
	// Payload holds while stalled; the prediction is made at the transfer.
	// ---------------------------------------------------------------------
	proc_entry_t cur_entry;
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			process_index <= '0;
			process_active <= 1'b0;
			pc_value <= '0;
			resident_map <= '0;
			pagein_ok <= 1'b0;
			end_of_sweep <= 1'b0;
			burst_left = 8;
			gap_left = 0;
			sweep_tick = 1;
			for (int i = 0; i < NPROC; i++)
				for (int j = 0; j < NPAGE; j++)
					use_stamp[i][j] = '0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				expected_actions.push_back(predict_replacement(cur_entry));
				entries_sent++;
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_entries.size() > 0) begin
				cur_entry = pending_entries.pop_front();
				process_index <= cur_entry.idx;
				process_active <= cur_entry.active;
				pc_value <= cur_entry.pc;
				resident_map <= cur_entry.map;
				pagein_ok <= cur_entry.ok;
				end_of_sweep <= cur_entry.eos;
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// mostly short gaps, some zero (back to back), now and then a long one
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25)
					                                       : $urandom_range(0, 3);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver stall pattern. One long hold-off after a few hundred results
	// lets the block fill up and push back on its input.
	// ---------------------------------------------------------------------
	rx_style_t rx_style;
	int style_left;
	int hold_left;
	bit hold_done;
	logic [3:0] rx_phase;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_style = RX_FREE;
			style_left = 100;
			hold_left = 0;
			hold_done = 1'b0;
			rx_phase = '0;
		end else begin
			if (!hold_done && results_seen >= HOLD_OFF_START) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (style_left == 0) begin
					rx_style = rx_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(20, 200);
				end else begin
					style_left--;
				end
				rx_phase = rx_phase + 4'd1;
				case (rx_style)
				RX_FREE:   out_stall <= 1'b0;
				RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
				RX_TOGGLE: out_stall <= rx_phase[1];
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result checker: every transfer on the output is matched to the oldest
	// prediction, field by field.
	// ---------------------------------------------------------------------
	replace_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_actions.size() == 0) begin
				$display("%0t: unexpected result, action %0h page %0h process %0h no_victim %0b",
				         $time, action, target_page, target_process, no_victim);
				errors++;
			end else begin
				want = expected_actions.pop_front();
				if (action !== want.act)
					report_mismatch("action", 32'(want.act), 32'(action));
				if (target_page !== want.page)
					report_mismatch("target_page", 32'(want.page), 32'(target_page));
				if (target_process !== want.proc_id)
					report_mismatch("target_process", 32'(want.proc_id), 32'(target_process));
				if (no_victim !== want.nv)
					report_mismatch("no_victim", 32'(want.nv), 32'(no_victim));
			end
		end
	end

	// Watchdog: cycles without a transfer on either side (covers the clearing pass too)
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				         $time, IDLE_LIMIT, expected_actions.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------------
	int sweep_len;
	int first_proc;
	int map_val;
	int idx;

	initial begin
		// Directed: inactive entry, page-in at the top page of the last process,
		// resident hit, refused page-in with nothing resident.
		push_entry(0, 0, 0, 16'h0000, 0, 0);
		push_entry(15, 1, 11'h7FF, 16'h0000, 1, 0);
		push_entry(1, 1, 0, 16'h0001, 0, 0);
		push_entry(2, 1, 5 * PAGE_SZ, 16'h0000, 0, 1);
		// inactive entry that closes a sweep still advances the tick
		push_entry(3, 0, 11'h7FF, 16'hFFFF, 0, 1);
		// all stamps equal: victim is the lowest resident page
		push_entry(4, 1, 0, 16'hFFFE, 0, 0);
		push_entry(5, 1, 15 * PAGE_SZ, 16'h7FFF, 0, 0);
		// build stamp history on process 1, then force LRU choices
		push_entry(1, 1, 3 * PAGE_SZ + 5, 16'h0008, 0, 1);
		push_entry(1, 1, 7 * PAGE_SZ, 16'h0080, 1, 1);
		push_entry(1, 1, 9 * PAGE_SZ, 16'h0089, 0, 0);
		push_entry(1, 1, 10 * PAGE_SZ, 16'h0288, 0, 0);
		push_entry(1, 1, 11 * PAGE_SZ, 16'h0680, 0, 1);
		// full map, extremes of pc, single resident page at either end
		push_entry(6, 1, 0, 16'hFFFF, 0, 1);
		push_entry(14, 1, 11'h7FF, 16'hFFFF, 1, 0);
		push_entry(7, 1, PAGE_SZ - 1, 16'hFFFE, 1, 0);
		push_entry(8, 1, 0, 16'h8000, 0, 0);
		push_entry(9, 1, 11'h7FF, 16'h0001, 0, 1);
		push_entry(15, 0, 0, 16'h0000, 1, 0);

		// Random: mostly well-formed sweeps over consecutive processes, some noise
		while (pending_entries.size() < NUM_ENTRIES) begin
			if ($urandom_range(0, 9) == 0) begin
				push_entry($urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 2047),
				           $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 1));
			end else begin
				sweep_len = $urandom_range(1, NPROC);
				first_proc = $urandom_range(0, NPROC - 1);
				for (int k = 0; k < sweep_len; k++) begin
					case ($urandom_range(0, 9))
					0:       map_val = 16'h0000;
					1:       map_val = 16'hFFFF;
					2:       map_val = 1 << $urandom_range(0, 15);
					3:       map_val = ~(1 << $urandom_range(0, 15)) & 16'hFFFF;
					4, 5:    map_val = $urandom_range(0, 65535) & $urandom_range(0, 65535);
					default: map_val = $urandom_range(0, 65535);
					endcase
					idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NPROC - 1)
					                                  : (first_proc + k) % NPROC;
					// refused page-ins dominate so the victim search runs often
					push_entry(idx, int'($urandom_range(0, 9) != 0), $urandom_range(0, 2047),
					           map_val, int'($urandom_range(0, 2) == 0), int'(k == sweep_len - 1));
				end
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(posedge clk);
		while (pending_entries.size() != 0 || in_valid || expected_actions.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d entries: %0d page-ins, %0d LRU page-outs, %0d with no victim,",
		         entries_sent, n_pagein, n_pageout, n_novictim);
		$display("%0d with no action; %0d sweeps ticked, one long output hold-off.",
		         n_none, sweep_tick - 1);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
